### hw/rtl/stereo_pixel_cost_disparity_select_macros.svh
// Assertion macros for the stereo disparity select block.
`ifndef STEREO_PIXEL_COST_DISPARITY_SELECT_MACROS_SVH
`define STEREO_PIXEL_COST_DISPARITY_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define SPCDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SPCDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPCDS_ASSERT_IMP(lbl, ante, cons, msg)
`define SPCDS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/spcds_pkg.sv
// Types and constants shared by the stereo disparity select block.
package spcds_pkg;

  localparam int unsigned DispW = 12;
  localparam int unsigned CostW = 18;
  localparam int unsigned PixW  = 24;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_MATCH = 1'b1
  } spcds_op_e;

  typedef enum logic {
    MODE_SAD = 1'b0,
    MODE_SSD = 1'b1
  } spcds_mode_e;

  typedef enum logic [2:0] {
    CFG_COST_MODE = 3'd0,
    CFG_MIN_DISP  = 3'd1,
    CFG_NUM_DISP  = 3'd2,
    CFG_IMG_WIDTH = 3'd3
  } spcds_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } spcds_state_e;

  typedef struct packed {
    spcds_op_e  op;
    logic [9:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } spcds_item_t;

  typedef struct packed {
    logic signed [DispW-1:0] disparity;
    logic [CostW-1:0]        best_cost;
  } spcds_res_t;

  // Per-candidate tag carried alongside the cost pipeline.
  typedef struct packed {
    logic signed [DispW-1:0] disp;
    logic                    first;
    logic                    last;
  } spcds_tag_t;

endpackage

### hw/rtl/spcds_cost.sv
// Two-stage pixel cost unit: RGB absolute differences, then SAD or squared sum.
module spcds_cost
  import spcds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  spcds_mode_e       mode_i,
  input  logic [PixW-1:0]   left_i,
  input  logic [PixW-1:0]   right_i,
  input  logic              in_range_i,
  input  spcds_tag_t        tag_i,
  output logic              valid_o,
  output logic [CostW-1:0]  cost_o,
  output spcds_tag_t        tag_o
);

  logic [7:0]  dr_d, dg_d, db_d;
  logic [7:0]  dr_q, dg_q, db_q;
  logic        va_q;
  spcds_tag_t  taga_q;
  logic [15:0] sr, sg, sb;
  logic [CostW-1:0] cost_d;
  logic [CostW-1:0] cost_q;
  logic        vb_q;
  spcds_tag_t  tagb_q;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Out-of-row candidates cost zero.
  always_comb begin
    dr_d = in_range_i ? absdiff(left_i[23:16], right_i[23:16]) : 8'd0;
    dg_d = in_range_i ? absdiff(left_i[15:8],  right_i[15:8])  : 8'd0;
    db_d = in_range_i ? absdiff(left_i[7:0],   right_i[7:0])   : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= dr_d;
    dg_q   <= dg_d;
    db_q   <= db_d;
    taga_q <= tag_i;
    cost_q <= cost_d;
    tagb_q <= taga_q;
  end

  always_comb begin
    sr = dr_q * dr_q;
    sg = dg_q * dg_q;
    sb = db_q * db_q;
    case (mode_i)
      MODE_SSD: cost_d = CostW'(sr) + CostW'(sg) + CostW'(sb);
      MODE_SAD: cost_d = CostW'(dr_q) + CostW'(dg_q) + CostW'(db_q);
      default:  cost_d = '0;
    endcase
  end

  assign valid_o = vb_q;
  assign cost_o  = cost_q;
  assign tag_o   = tagb_q;

endmodule

### hw/rtl/stereo_pixel_cost_disparity_select.sv
// Top level: row memory, disparity sequencer and winner-take-all select.
//
//   channel   handshake                    payload
//   item      start / busy                 item_i  (op, column, red, green, blue)
//   result    res_valid_o (1-cycle strobe) res_o   (disparity, best_cost)
//   config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A store item writes the row memory at the accept edge and never raises busy.
// A match item with N disparities (N = min(num_disparities, MAX_DISP)) reads the
// row memory once per disparity, one read per cycle; busy is high until the strobe
// comes. With N zero the strobe follows at once.
// Reset clears control state and configuration; data registers and row memory contents are undefined.
// The result strobe cannot be stalled.
`include "stereo_pixel_cost_disparity_select_macros.svh"

module stereo_pixel_cost_disparity_select
  import spcds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_DISP  = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  spcds_item_t  item_i,
  output logic         res_valid_o,
  output spcds_res_t   res_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [10:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned KW = $clog2(MAX_DISP + 1);
  localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
  localparam logic [8:0]  MaxD = 9'(MAX_DISP);

  // configuration
  spcds_mode_e        mode_q;
  logic signed [10:0] min_disp_q;
  logic [6:0]         num_disp_q;
  logic [10:0]        img_width_q;

  // sequencer
  spcds_state_e st_q, st_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [9:0]    col_q;
  logic [PixW-1:0] pix_q;
  logic [8:0]    cnt_sat;
  logic          accept, match_acc, store_acc, issue_en, last_issue;

  // issue address
  logic signed [DispW-1:0] d_s;
  logic signed [13:0]      c2_s;
  logic                    in_range;
  logic [AW-1:0]           rd_addr, wr_addr;

  // memory and stage 1
  logic [PixW-1:0] mem [MAX_WIDTH];
  logic [PixW-1:0] rd_data_q;
  logic            v1_q;
  logic            inr1_q;
  spcds_tag_t      tag1_q, tag_iss;

  // cost output and select
  logic             v3;
  logic [CostW-1:0] cost3;
  spcds_tag_t       tag3;
  logic             better;
  logic signed [DispW-1:0] best_d_q, sel_d;
  logic [CostW-1:0]        best_cost_q, sel_cost;
  logic       res_valid_q, res_valid_d;
  spcds_res_t res_q, res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SAD;
      min_disp_q  <= '0;
      num_disp_q  <= 7'd16;
      img_width_q <= 11'd640;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COST_MODE: mode_q      <= spcds_mode_e'(cfg_data_i[0]);
        CFG_MIN_DISP:  min_disp_q  <= $signed(cfg_data_i);
        CFG_NUM_DISP:  num_disp_q  <= cfg_data_i[6:0];
        CFG_IMG_WIDTH: img_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept    = start && !busy;
  assign match_acc = accept && (item_i.op == OP_MATCH);
  assign store_acc = accept && (item_i.op == OP_STORE) && ({4'b0000, item_i.column} < MaxW);
  assign cnt_sat   = ({2'b00, num_disp_q} > MaxD) ? MaxD : {2'b00, num_disp_q};
  assign last_issue = (k_q == cnt_q - KW'(1));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (match_acc && (cnt_sat != 9'd0)) st_d = ST_ISSUE;
      ST_ISSUE: if (last_issue) st_d = ST_DRAIN;
      ST_DRAIN: if (v3 && tag3.last) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b1;
    issue_en = 1'b0;
    case (st_q)
      ST_IDLE:  busy = 1'b0;
      ST_ISSUE: issue_en = 1'b1;
      ST_DRAIN: ;
      default:  busy = 1'b0;
    endcase
  end

  always_comb begin
    k_d   = k_q;
    cnt_d = cnt_q;
    if (match_acc) begin
      k_d   = '0;
      cnt_d = KW'(cnt_sat);
    end else if (issue_en) begin
      k_d = k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      k_q   <= '0;
      cnt_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      k_q   <= k_d;
      cnt_q <= cnt_d;
      v1_q  <= issue_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_acc) begin
      col_q <= item_i.column;
      pix_q <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  // candidate column = column - disparity
  always_comb begin
    d_s  = {min_disp_q[10], min_disp_q} + $signed(DispW'(k_q));
    c2_s = $signed({4'b0000, col_q}) - {{2{d_s[DispW-1]}}, d_s};
    in_range = !c2_s[13] && (c2_s < $signed({3'b000, img_width_q}))
               && ($unsigned(c2_s) < MaxW);
    rd_addr = c2_s[AW-1:0];
    wr_addr = AW'(item_i.column);
    tag_iss.disp  = d_s;
    tag_iss.first = (k_q == '0);
    tag_iss.last  = last_issue;
  end

  always_ff @(posedge clk_i) begin
    if (store_acc) begin
      mem[wr_addr] <= {item_i.red, item_i.green, item_i.blue};
    end
    if (issue_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    inr1_q <= in_range;
    tag1_q <= tag_iss;
  end

  spcds_cost u_cost (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q),
    .mode_i     (mode_q),
    .left_i     (pix_q),
    .right_i    (rd_data_q),
    .in_range_i (inr1_q),
    .tag_i      (tag1_q),
    .valid_o    (v3),
    .cost_o     (cost3),
    .tag_o      (tag3)
  );

  // first strict minimum wins
  always_comb begin
    better   = tag3.first || (cost3 < best_cost_q);
    sel_d    = better ? tag3.disp : best_d_q;
    sel_cost = better ? cost3 : best_cost_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (v3 && tag3.last) begin
      res_valid_d     = 1'b1;
      res_d.disparity = sel_d;
      res_d.best_cost = sel_cost;
    end else if (match_acc && (cnt_sat == 9'd0)) begin
      res_valid_d = 1'b1;
      res_d       = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3) begin
      best_d_q    <= sel_d;
      best_cost_q <= sel_cost;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SPCDS_ASSERT_IMP(a_idle_empty, !busy, !v1_q && !v3, "pipeline not empty while idle")
  `SPCDS_ASSERT_NXT(a_last_result, v3 && tag3.last, res_valid_q, "last candidate gave no result")
  `SPCDS_ASSERT_IMP(a_issue_range, st_q == ST_ISSUE, k_q < cnt_q, "issue index past count")
  `SPCDS_ASSERT_IMP(a_sad_bound, v3 && (mode_q == MODE_SAD), cost3 <= 18'd765, "SAD cost too big")
  `SPCDS_ASSERT_NXT(a_match_busy, match_acc && (cnt_sat != 9'd0), busy, "match item not busy")

endmodule
